// ----- hdl/sir_pkg.sv -----
// ----------------------------------------------------------------------------
// sir_pkg
// Widths, codes and shared types of the SIR Euler stepper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sir_pkg;

  // value format
  localparam int VALUE_W = 48;
  localparam int FRAC_W  = 16;
  localparam int IN_W    = 47;
  localparam int TIME_W  = 47;
  localparam int STEP_W  = 32;

  // register widths
  localparam int BETA_W     = 24;
  localparam int GAMMA_W    = 24;
  localparam int DT_W       = 20;
  localparam int SAVE_W     = 16;
  localparam int LIMIT_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INFECTION = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RECOVERY  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SAVE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT     = 3'd4;

  // operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // stream packing
  localparam int IN_FIELDS_W  = 3 * IN_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = STEP_W + TIME_W + 3 * VALUE_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // shared arithmetic unit
  localparam int MUL_A_W    = BETA_W + VALUE_W;
  localparam int MUL_B_W    = VALUE_W;
  localparam int ACC_W      = MUL_A_W + MUL_B_W;
  localparam int DIGIT_W    = 8;
  localparam int DIG_SHORT  = (BETA_W + DIGIT_W - 1) / DIGIT_W;
  localparam int DIG_LONG   = MUL_B_W / DIGIT_W;
  localparam int B_SHORT_W  = DIG_SHORT * DIGIT_W;
  localparam int DIG_CNT_W  = $clog2(DIG_LONG + 1);
  localparam int SUM_W      = VALUE_W + 2;
  localparam int N_W        = SUM_W - FRAC_W;
  localparam int DQ_W       = ACC_W - 2 * FRAC_W;
  localparam int DIV_STEPS  = DQ_W / 2;
  localparam int CNT_W      = $clog2(DIV_STEPS + 1);

  localparam logic [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  typedef struct packed {
    logic [BETA_W-1:0]  infection_rate;
    logic [GAMMA_W-1:0] recovery_rate;
    logic [DT_W-1:0]    time_step;
    logic [SAVE_W-1:0]  save_interval;
    logic [LIMIT_W-1:0] step_limit;
  } cfg_t;

  typedef struct packed {
    logic               last;
    logic [VALUE_W-1:0] recovered;
    logic [VALUE_W-1:0] infected;
    logic [VALUE_W-1:0] susceptible;
    logic [TIME_W-1:0]  time_value;
    logic [STEP_W-1:0]  step_index;
  } snap_t;

  typedef struct packed {
    logic                 start;
    logic                 div_mode;
    logic [DIG_CNT_W-1:0] digits;
  } arith_cmd_t;

endpackage

`default_nettype wire

// ----- hdl/sir_arith.sv -----
// ----------------------------------------------------------------------------
// sir_arith
// Shared multiply / divide unit: byte-digit multiply into a wide
// accumulator, or restoring divide two quotient bits per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sir_arith (
  input  logic                        clk,
  input  logic                        rst,
  input  sir_pkg::arith_cmd_t         cmd,
  input  logic [sir_pkg::MUL_A_W-1:0] a_in,
  input  logic [sir_pkg::MUL_B_W-1:0] b_in,
  input  logic [sir_pkg::N_W-1:0]     d_in,
  output logic                        busy,
  output logic [sir_pkg::ACC_W-1:0]   acc
);
  import sir_pkg::*;

  logic [MUL_A_W-1:0]         a_reg;
  logic [MUL_B_W-1:0]         b_reg;
  logic [N_W-1:0]             d_reg;
  logic [N_W-1:0]             rem;
  logic [CNT_W-1:0]           cnt;
  logic                       div_mode;
  logic [DIGIT_W-1:0]         digit;
  logic [MUL_A_W+DIGIT_W-1:0] partial;
  logic [ACC_W-1:0]           mul_next;
  logic [DQ_W-1:0]            dq;
  logic [N_W:0]               r1;
  logic [N_W:0]               r2;
  logic                       ge1;
  logic                       ge2;
  logic [N_W-1:0]             rem1;
  logic [N_W-1:0]             rem2;

  always_comb begin
    digit    = b_reg[MUL_B_W-1 -: DIGIT_W];
    partial  = a_reg * digit;
    mul_next = (acc << DIGIT_W) + ACC_W'(partial);

    dq   = acc[DQ_W-1:0];
    r1   = {rem, dq[DQ_W-1]};
    ge1  = r1 >= {1'b0, d_reg};
    rem1 = ge1 ? N_W'(r1 - {1'b0, d_reg}) : r1[N_W-1:0];
    r2   = {rem1, dq[DQ_W-2]};
    ge2  = r2 >= {1'b0, d_reg};
    rem2 = ge2 ? N_W'(r2 - {1'b0, d_reg}) : r2[N_W-1:0];
  end

  assign busy = (cnt != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.start) begin
      cnt <= cmd.div_mode ? CNT_W'(DIV_STEPS) : CNT_W'(cmd.digits);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      div_mode <= cmd.div_mode;
      if (cmd.div_mode) begin
        acc   <= acc >> (2 * FRAC_W);
        rem   <= '0;
        d_reg <= d_in;
      end else begin
        acc   <= '0;
        a_reg <= a_in;
        b_reg <= b_in;
      end
    end else if (busy) begin
      if (div_mode) begin
        acc <= ACC_W'({dq[DQ_W-3:0], ge1, ge2});
        rem <= rem2;
      end else begin
        acc   <= mul_next;
        b_reg <= b_reg << DIGIT_W;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/sir_seq.sv -----
// ----------------------------------------------------------------------------
// sir_seq
// Step sequencer: holds the populations and run counters and drives the
// shared arithmetic unit through one Euler step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sir_seq (
  input  logic                     clk,
  input  logic                     rst,
  input  sir_pkg::cfg_t            cfg,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_op,
  input  logic [sir_pkg::IN_W-1:0] in_sus,
  input  logic [sir_pkg::IN_W-1:0] in_inf,
  input  logic [sir_pkg::IN_W-1:0] in_rec,
  input  logic                     out_free,
  output logic                     snap_load,
  output sir_pkg::snap_t           snap
);
  import sir_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_TIME_W = 4'd1;
  localparam logic [3:0] ST_SNAP   = 4'd2;
  localparam logic [3:0] ST_SUM    = 4'd3;
  localparam logic [3:0] ST_P1_W   = 4'd4;
  localparam logic [3:0] ST_P2_W   = 4'd5;
  localparam logic [3:0] ST_DIV_W  = 4'd6;
  localparam logic [3:0] ST_G_W    = 4'd7;
  localparam logic [3:0] ST_DI_W   = 4'd8;
  localparam logic [3:0] ST_DR_W   = 4'd9;
  localparam logic [3:0] ST_UPD1   = 4'd10;
  localparam logic [3:0] ST_UPD2   = 4'd11;

  function automatic logic [VALUE_W-1:0] mag(input logic [VALUE_W-1:0] v);
    return v[VALUE_W-1] ? VALUE_W'(0) - v : v;
  endfunction

  function automatic logic [VALUE_W-1:0] sat_mag(input logic [ACC_W-1:0] m, input logic neg);
    logic big;
    big = |m[ACC_W-1:VALUE_W-1];
    if (!neg) return big ? VAL_MAX : m[VALUE_W-1:0];
    if (big) return VAL_MIN;
    return VALUE_W'(0) - m[VALUE_W-1:0];
  endfunction

  function automatic logic [VALUE_W-1:0] sat_add(input logic [VALUE_W-1:0] a,
                                                 input logic [VALUE_W-1:0] b);
    logic [VALUE_W:0] s;
    s = {a[VALUE_W-1], a} + {b[VALUE_W-1], b};
    if (s[VALUE_W] != s[VALUE_W-1]) return s[VALUE_W] ? VAL_MIN : VAL_MAX;
    return s[VALUE_W-1:0];
  endfunction

  function automatic logic [VALUE_W-1:0] neg_sat(input logic [VALUE_W-1:0] d);
    return (d == VAL_MIN) ? VAL_MAX : VALUE_W'(0) - d;
  endfunction

  function automatic logic [MUL_B_W-1:0] b_short(input logic [B_SHORT_W-1:0] x);
    return {x, {(MUL_B_W-B_SHORT_W){1'b0}}};
  endfunction

  logic [3:0]         state;
  logic [3:0]         state_next;
  logic [VALUE_W-1:0] susceptible;
  logic [VALUE_W-1:0] infected;
  logic [VALUE_W-1:0] recovered;
  logic [STEP_W-1:0]  step_counter;
  logic [SAVE_W-1:0]  save_phase;
  logic               finished;

  logic [N_W-1:0]     nmag;
  logic               inf_neg;
  logic [VALUE_W-1:0] inf_term;
  logic [VALUE_W-1:0] g_term;
  logic [VALUE_W-1:0] dinf;
  logic [VALUE_W-1:0] drec;

  arith_cmd_t         cmd;
  logic [MUL_A_W-1:0] a_in;
  logic [MUL_B_W-1:0] b_in;
  logic               busy;
  logic [ACC_W-1:0]   acc;

  logic               accept;
  logic               run;
  logic [SUM_W-1:0]   sum_all;
  logic [SUM_W-1:0]   abs_sum;
  logic [N_W-1:0]     n_now;
  logic [TIME_W-1:0]  t_sat;
  logic [SAVE_W-1:0]  interval;
  logic [SAVE_W:0]    phase_inc;

  sir_arith u_arith (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .a_in (a_in),
    .b_in (b_in),
    .d_in (nmag),
    .busy (busy),
    .acc  (acc)
  );

  always_comb begin
    sum_all = {{(SUM_W-VALUE_W){susceptible[VALUE_W-1]}}, susceptible}
            + {{(SUM_W-VALUE_W){infected[VALUE_W-1]}}, infected}
            + {{(SUM_W-VALUE_W){recovered[VALUE_W-1]}}, recovered};
    abs_sum = sum_all[SUM_W-1] ? SUM_W'(0) - sum_all : sum_all;
    n_now   = abs_sum[SUM_W-1:FRAC_W];
    t_sat   = (|acc[ACC_W-1:TIME_W]) ? {TIME_W{1'b1}} : acc[TIME_W-1:0];

    interval  = (cfg.save_interval == '0) ? SAVE_W'(1) : cfg.save_interval;
    phase_inc = {1'b0, save_phase} + 1'b1;

    snap.step_index  = step_counter;
    snap.time_value  = t_sat;
    snap.susceptible = susceptible;
    snap.infected    = infected;
    snap.recovered   = recovered;
    snap.last        = (step_counter == cfg.step_limit);
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.digits = DIG_CNT_W'(DIG_SHORT);
    a_in       = '0;
    b_in       = '0;
    snap_load  = 1'b0;
    in_ready   = (state == ST_IDLE);
    accept     = in_valid && in_ready;
    run        = accept && (in_op == OP_STEP) && !finished
              && (step_counter <= cfg.step_limit);
    case (state)
      ST_IDLE: begin
        if (run) begin
          if (save_phase == '0) begin
            cmd.start  = 1'b1;
            a_in       = MUL_A_W'(step_counter);
            b_in       = b_short(B_SHORT_W'(cfg.time_step));
            state_next = ST_TIME_W;
          end else begin
            state_next = ST_SUM;
          end
        end
      end
      ST_TIME_W: begin
        if (!busy) state_next = ST_SNAP;
      end
      ST_SNAP: begin
        if (out_free) begin
          snap_load  = 1'b1;
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd.start = 1'b1;
        a_in      = MUL_A_W'(mag(infected));
        if (n_now == '0) begin
          b_in       = b_short(B_SHORT_W'(cfg.recovery_rate));
          state_next = ST_G_W;
        end else begin
          b_in       = b_short(B_SHORT_W'(cfg.infection_rate));
          state_next = ST_P1_W;
        end
      end
      ST_P1_W: begin
        if (!busy) begin
          cmd.start  = 1'b1;
          cmd.digits = DIG_CNT_W'(DIG_LONG);
          a_in       = acc[MUL_A_W-1:0];
          b_in       = mag(susceptible);
          state_next = ST_P2_W;
        end
      end
      ST_P2_W: begin
        if (!busy) begin
          cmd.start    = 1'b1;
          cmd.div_mode = 1'b1;
          state_next   = ST_DIV_W;
        end
      end
      ST_DIV_W: begin
        if (!busy) begin
          cmd.start  = 1'b1;
          a_in       = MUL_A_W'(mag(infected));
          b_in       = b_short(B_SHORT_W'(cfg.recovery_rate));
          state_next = ST_G_W;
        end
      end
      ST_G_W: begin
        if (!busy) begin
          cmd.start  = 1'b1;
          a_in       = MUL_A_W'(mag(inf_term));
          b_in       = b_short(B_SHORT_W'(cfg.time_step));
          state_next = ST_DI_W;
        end
      end
      ST_DI_W: begin
        if (!busy) begin
          cmd.start  = 1'b1;
          a_in       = MUL_A_W'(mag(g_term));
          b_in       = b_short(B_SHORT_W'(cfg.time_step));
          state_next = ST_DR_W;
        end
      end
      ST_DR_W: begin
        if (!busy) state_next = ST_UPD1;
      end
      ST_UPD1: state_next = ST_UPD2;
      ST_UPD2: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      susceptible  <= '0;
      infected     <= '0;
      recovered    <= '0;
      step_counter <= '0;
      save_phase   <= '0;
      finished     <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (accept && in_op == OP_LOAD) begin
            susceptible  <= VALUE_W'(in_sus);
            infected     <= VALUE_W'(in_inf);
            recovered    <= VALUE_W'(in_rec);
            step_counter <= '0;
            save_phase   <= '0;
            finished     <= 1'b0;
          end
        end
        ST_UPD1: begin
          susceptible <= sat_add(susceptible, neg_sat(dinf));
          infected    <= sat_add(infected, dinf);
          recovered   <= sat_add(recovered, drec);
        end
        ST_UPD2: begin
          infected <= sat_add(infected, neg_sat(drec));
          if (step_counter == cfg.step_limit) begin
            finished <= 1'b1;
          end else begin
            step_counter <= step_counter + 1'b1;
          end
          save_phase <= (phase_inc >= {1'b0, interval}) ? '0 : phase_inc[SAVE_W-1:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_SUM: begin
        nmag    <= n_now;
        inf_neg <= infected[VALUE_W-1] ^ susceptible[VALUE_W-1] ^ sum_all[SUM_W-1];
        if (n_now == '0) inf_term <= '0;
      end
      ST_DIV_W: if (!busy) inf_term <= sat_mag(acc, inf_neg);
      ST_G_W:   if (!busy) g_term <= sat_mag(acc >> FRAC_W, infected[VALUE_W-1]);
      ST_DI_W:  if (!busy) dinf <= sat_mag(acc >> FRAC_W, inf_term[VALUE_W-1]);
      ST_DR_W:  if (!busy) drec <= sat_mag(acc >> FRAC_W, g_term[VALUE_W-1]);
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/sir_epidemic_euler_stepper.sv -----
// ----------------------------------------------------------------------------
// sir_epidemic_euler_stepper
// Forward-Euler SIR stepper in signed Q32.16 with snapshot output.
// ----------------------------------------------------------------------------
// channel  | dir | beat
// s_axis   | in  | tdata: S, I, R populations; tuser: operation (0 load, 1 step)
// m_axis   | out | tdata: step, time, S, I, R snapshot; tlast: step limit reached
// cfg      | in  | cfg_index selects register, cfg_data written value
//
// load: taken while idle. A step runs longer with a snapshot, and is shorter
// when the total population is below one. The divider (two quotient bits
// per cycle) and the byte-digit multiplier set the length of a step.
// rst (synchronous) clears populations, counters and registers to defaults.
// A stalled m_axis holds the step in its snapshot state; input is taken
// only between steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sir_epidemic_euler_stepper (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // susceptible_in, infected_in, recovered_in
  input  logic [sir_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // operation
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // step_index, time_value, susceptible_out, infected_out, recovered_out
  output logic [sir_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic                           m_axis_tlast,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sir_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sir_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sir_pkg::*;

  cfg_t  cfg;
  snap_t snap;
  snap_t out_snap;
  logic  snap_load;
  logic  out_valid;
  logic  out_free;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.infection_rate <= BETA_W'(19661);
      cfg.recovery_rate  <= GAMMA_W'(6554);
      cfg.time_step      <= DT_W'(6554);
      cfg.save_interval  <= SAVE_W'(1);
      cfg.step_limit     <= LIMIT_W'(1000);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_INFECTION: cfg.infection_rate <= cfg_data[BETA_W-1:0];
        REG_RECOVERY:  cfg.recovery_rate  <= cfg_data[GAMMA_W-1:0];
        REG_TIME_STEP: cfg.time_step      <= cfg_data[DT_W-1:0];
        REG_SAVE:      cfg.save_interval  <= cfg_data[SAVE_W-1:0];
        REG_LIMIT:     cfg.step_limit     <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  sir_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_op     (s_axis_tuser),
    .in_sus    (s_axis_tdata[IN_W-1:0]),
    .in_inf    (s_axis_tdata[2*IN_W-1:IN_W]),
    .in_rec    (s_axis_tdata[3*IN_W-1:2*IN_W]),
    .out_free  (out_free),
    .snap_load (snap_load),
    .snap      (snap)
  );

  // output register
  assign out_free = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (snap_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_load) out_snap <= snap;
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = out_snap.last;
  assign m_axis_tdata  = OUT_DATA_W'({out_snap.recovered, out_snap.infected,
                                      out_snap.susceptible, out_snap.time_value,
                                      out_snap.step_index});

endmodule

`default_nettype wire

// ----- hdl/sir_checker.sv -----
// ----------------------------------------------------------------------------
// sir_checker
// Port-level checks of the SIR stepper, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sir_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           s_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [sir_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                           m_axis_tlast
);
  import sir_pkg::*;

  // reset leaves no beat pending and the input open
  a_reset_clean: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && s_axis_tready)
    else $error("output pending or input closed after reset");

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled output beat changed");

  // after a load the input is ready again in the next cycle
  a_load_quick: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_LOAD |=> s_axis_tready)
    else $error("input not reopened after load");

  // snapshots appear only while a step is in progress
  a_snap_in_step: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> !s_axis_tready)
    else $error("snapshot issued outside a step");

endmodule

bind sir_epidemic_euler_stepper sir_checker u_chk (.*);

`default_nettype wire
